// ===== design/ffsa_pkg.sv =====
// Shared types and constants for the first-fit segment allocator.
`default_nettype none
package ffsa_pkg;

  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned START_W = 16;
  localparam logic [SIZE_W-1:0] HEAP_MAX = 17'h10000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

endpackage
`default_nettype wire

// ===== design/first_fit_segment_allocator.sv =====
// First-fit heap segment allocator with split and coalescing, table in one memory.
//
//  channel   dir  handshake                  payload
//  in        in   in_valid / in_ready        mode, owner_id, request_size, block_start
//  out       out  out_valid / out_ready      status, start_out
//  cfg       in   cfg_wr_en (no wait)        cfg_wr_data (heap size)
//
// One word at a time: each segment scanned takes a read and a check state (S_RD, S_CHK;
// the memory read is registered), and each entry shifted on a split or merge takes a
// read and a write state (S_MVRD, S_MVWR). After reset or a cfg write the S_INIT state
// rebuilds entry 0. A new word is taken while the previous result waits in the
// output register; a stalled output holds the block in its final state only.
`default_nettype none
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned OWNER_BITS   = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                mode,
  input  wire logic [7:0]          owner_id,
  input  wire logic [SIZE_W-1:0]   request_size,
  input  wire logic [START_W-1:0]  block_start,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               status,
  output logic [START_W-1:0]       start_out,
  input  wire logic                cfg_wr_en,
  input  wire logic [SIZE_W-1:0]   cfg_wr_data
);

  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IW = CW + 1;

  typedef struct packed {
    logic [START_W-1:0]    start;
    logic [SIZE_W-1:0]     size;
    logic                  free;
    logic [OWNER_BITS-1:0] owner;
  } ent_t;

  typedef enum logic [10:0] {
    S_INIT  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_CHK   = 11'b00000001000,
    S_NXRD  = 11'b00000010000,
    S_NXCHK = 11'b00000100000,
    S_MVRD  = 11'b00001000000,
    S_MVWR  = 11'b00010000000,
    S_FIX1  = 11'b00100000000,
    S_FIX2  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  ent_t mem [MAX_SEGMENTS];
  ent_t rdata;
  logic [AW-1:0] raddr, waddr;
  logic we;
  ent_t wdata;

  state_t st;
  logic [SIZE_W-1:0] heap;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic mode_r;
  logic [OWNER_BITS-1:0] own_r;
  logic [SIZE_W-1:0] req_r;
  logic [START_W-1:0] blk_r;
  ent_t cur, prv;
  logic mv_up, mv_two;
  logic [IW-1:0] mv_dst, mv_lim;
  logic [IW-1:0] w1_addr, w2_addr;
  ent_t w1_data, w2_data;
  logic w2_en;
  status_t res_st;
  logic [START_W-1:0] res_start;

  logic [IW-1:0] count_x, mv_src, idx_p1;
  logic mv_stop, right, left, fit, match;
  logic [SIZE_W-1:0] cfg_clamped;
  logic out_load;

  assign count_x = IW'(count);
  assign idx_p1  = idx + IW'(1);
  assign mv_src  = mv_up ? mv_dst - IW'(1) : mv_dst + (mv_two ? IW'(2) : IW'(1));
  assign mv_stop = mv_up ? (mv_dst < mv_lim) : (mv_src >= mv_lim);
  assign fit     = rdata.free && (rdata.size >= req_r);
  assign match   = !rdata.free && (rdata.owner == own_r) && (rdata.start == blk_r);
  assign right   = (idx_p1 < count_x) && rdata.free;
  assign left    = (idx != '0) && prv.free;
  assign in_ready = (st == S_IDLE);
  assign out_load = (st == S_DONE) && !cfg_wr_en && (!out_valid || out_ready);

  always_comb begin
    if (cfg_wr_data == '0) cfg_clamped = SIZE_W'(1);
    else if (cfg_wr_data > HEAP_MAX) cfg_clamped = HEAP_MAX;
    else cfg_clamped = cfg_wr_data;
  end

  // memory port control
  always_comb begin
    raddr = idx[AW-1:0];
    we    = 1'b0;
    waddr = w1_addr[AW-1:0];
    wdata = w1_data;
    unique case (st)
      S_INIT: begin
        we = 1'b1;
        waddr = '0;
        wdata = '{start: '0, size: heap, free: 1'b1, owner: '0};
      end
      S_NXRD: raddr = idx_p1[AW-1:0];
      S_MVRD: raddr = mv_src[AW-1:0];
      S_MVWR: begin
        we = 1'b1;
        waddr = mv_dst[AW-1:0];
        wdata = rdata;
      end
      S_FIX1: we = 1'b1;
      S_FIX2: begin
        we = 1'b1;
        waddr = w2_addr[AW-1:0];
        wdata = w2_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_INIT;
      heap <= HEAP_MAX;
      count <= CW'(1);
    end else begin
      if (cfg_wr_en) begin
        heap <= cfg_clamped;
        st <= S_INIT;
      end else begin
        unique case (st)
          S_INIT: begin
            count <= CW'(1);
            st <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid) begin
              mode_r <= mode;
              own_r  <= OWNER_BITS'(owner_id);
              req_r  <= request_size;
              blk_r  <= block_start;
              idx    <= '0;
              // no move by default: up with dst below the limit
              mv_up  <= 1'b1;
              mv_two <= 1'b0;
              mv_dst <= '0;
              mv_lim <= IW'(1);
              w2_en  <= 1'b0;
              res_start <= '0;
              if (mode == MODE_ALLOC && request_size == '0) begin
                res_st <= ST_NOFIT;
                st <= S_DONE;
              end else begin
                st <= S_RD;
              end
            end
          end
          S_RD: begin
            if (idx == count_x) begin
              res_st <= (mode_r == MODE_FREE) ? ST_NOTFOUND : ST_NOFIT;
              st <= S_DONE;
            end else begin
              st <= S_CHK;
            end
          end
          S_CHK: begin
            cur <= rdata;
            if (mode_r == MODE_ALLOC && fit) begin
              res_st <= ST_OK;
              res_start <= rdata.start;
              w1_addr <= idx;
              if (rdata.size == req_r) begin
                w1_data <= '{start: rdata.start, size: rdata.size, free: 1'b0,
                             owner: own_r};
                st <= S_MVRD;
              end else if (count_x == IW'(MAX_SEGMENTS)) begin
                res_st <= ST_FULL;
                res_start <= '0;
                st <= S_DONE;
              end else begin
                // split: open a slot at idx+1 for the free remainder
                w1_addr <= idx_p1;
                w1_data <= '{start: START_W'(rdata.start + req_r),
                             size: rdata.size - req_r, free: 1'b1, owner: '0};
                w2_en   <= 1'b1;
                w2_addr <= idx;
                w2_data <= '{start: rdata.start, size: req_r, free: 1'b0, owner: own_r};
                mv_dst  <= count_x;
                mv_lim  <= idx + IW'(2);
                count   <= count + CW'(1);
                st <= S_MVRD;
              end
            end else if (mode_r == MODE_FREE && match) begin
              st <= S_NXRD;
            end else begin
              prv <= rdata;
              idx <= idx_p1;
              st <= S_RD;
            end
          end
          S_NXRD: st <= S_NXCHK;
          S_NXCHK: begin
            res_st <= ST_OK;
            mv_up  <= 1'b0;
            mv_lim <= count_x;
            if (left && right) begin
              w1_addr <= idx - IW'(1);
              w1_data <= '{start: prv.start, size: prv.size + cur.size + rdata.size,
                           free: 1'b1, owner: prv.owner};
              mv_two <= 1'b1;
              mv_dst <= idx;
              count  <= count - CW'(2);
            end else if (left) begin
              w1_addr <= idx - IW'(1);
              w1_data <= '{start: prv.start, size: prv.size + cur.size,
                           free: 1'b1, owner: prv.owner};
              mv_dst <= idx;
              count  <= count - CW'(1);
            end else if (right) begin
              w1_addr <= idx;
              w1_data <= '{start: cur.start, size: cur.size + rdata.size,
                           free: 1'b1, owner: cur.owner};
              mv_dst <= idx_p1;
              count  <= count - CW'(1);
            end else begin
              w1_addr <= idx;
              w1_data <= '{start: cur.start, size: cur.size, free: 1'b1,
                           owner: cur.owner};
              mv_up  <= 1'b1;
              mv_lim <= IW'(1);
              mv_dst <= '0;
            end
            st <= S_MVRD;
          end
          S_MVRD: st <= mv_stop ? S_FIX1 : S_MVWR;
          S_MVWR: begin
            mv_dst <= mv_up ? mv_dst - IW'(1) : mv_dst + IW'(1);
            st <= S_MVRD;
          end
          S_FIX1: st <= w2_en ? S_FIX2 : S_DONE;
          S_FIX2: st <= S_DONE;
          S_DONE: begin
            if (out_load) begin
              status    <= res_st;
              start_out <= res_start;
              st <= S_IDLE;
            end
          end
          default: st <= S_INIT;
        endcase
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count_x <= IW'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !cfg_wr_en) |=> !in_ready)
    else $error("accepted a word while busy");

  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (st == S_INIT))
    else $error("cfg write did not rebuild table");

endmodule
`default_nettype wire

// ===== verif/first_fit_segment_allocator_test.sv =====
// Self-checking testbench for the first-fit segment allocator: heap table predictor and scoreboard.
module first_fit_segment_allocator_test;
  import ffsa_pkg::*;

  localparam int NSEG = 64;
  localparam int CFG_INDEX = 0;
  localparam int DRAIN_CYCLES = 600;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    mode_t       op;
    logic [7:0]  owner;
    logic [16:0] req;
    logic [15:0] blk;
  } word_t;

  typedef struct packed {
    status_t     st;
    logic [15:0] start;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic mode = 0;
  logic [7:0] owner_id = 0;
  logic [16:0] request_size = 0;
  logic [15:0] block_start = 0;
  logic cfg_wr_en = 0;
  logic [16:0] cfg_wr_data = 0;
  logic in_ready, out_valid;
  logic [1:0] status;
  logic [15:0] start_out;

  first_fit_segment_allocator u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .owner_id(owner_id), .request_size(request_size),
    .block_start(block_start), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .start_out(start_out), .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // heap table predictor
  logic [16:0] heap_words;
  logic [15:0] t_start[NSEG];
  logic [16:0] t_size[NSEG];
  logic        t_free[NSEG];
  logic [7:0]  t_owner[NSEG];
  int          t_count;

  word_t   pending_words[$];
  answer_t expected_answers[$];
  int mismatches = 0;
  bit timed_out = 0;
  bit hold_rx = 0;
  bit hold_go = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  bit stim_done = 0;
  int cycles = 0;
  bit acc_flag = 0;
  // live allocations, to build sensible free requests
  logic [7:0]  live_owner[$];
  logic [15:0] live_start[$];

  function automatic void heap_reset(input logic [16:0] v);
    heap_words = (v == 0) ? 17'd1 : (v > HEAP_MAX ? HEAP_MAX : v);
    for (int k = 0; k < NSEG; k++) begin
      t_start[k] = 0; t_size[k] = 0; t_free[k] = 0; t_owner[k] = 0;
    end
    t_count = 1;
    t_size[0] = heap_words;
    t_free[0] = 1;
  endfunction

  function automatic void drop_entry(input int idx);
    for (int k = idx; k + 1 < t_count; k++) begin
      t_start[k] = t_start[k+1]; t_size[k] = t_size[k+1];
      t_free[k] = t_free[k+1]; t_owner[k] = t_owner[k+1];
    end
    t_count--;
  endfunction

  function automatic answer_t heap_apply(input word_t w);
    answer_t a;
    a.st = ST_NOFIT;
    a.start = 0;
    if (w.op == MODE_ALLOC) begin
      if (w.req != 0) begin
        for (int i = 0; i < t_count; i++) begin
          if (!t_free[i] || t_size[i] < w.req) continue;
          if (t_size[i] == w.req) begin
            t_free[i] = 0; t_owner[i] = w.owner;
            a.st = ST_OK; a.start = t_start[i];
          end else if (t_count >= NSEG) begin
            a.st = ST_FULL;
          end else begin
            for (int k = t_count; k > i + 1; k--) begin
              t_start[k] = t_start[k-1]; t_size[k] = t_size[k-1];
              t_free[k] = t_free[k-1]; t_owner[k] = t_owner[k-1];
            end
            t_start[i+1] = t_start[i] + w.req[15:0];
            t_size[i+1] = t_size[i] - w.req;
            t_free[i+1] = 1; t_owner[i+1] = 0;
            t_size[i] = w.req; t_free[i] = 0; t_owner[i] = w.owner;
            t_count++;
            a.st = ST_OK; a.start = t_start[i];
          end
          break;
        end
      end
    end else begin
      a.st = ST_NOTFOUND;
      for (int i = 0; i < t_count; i++) begin
        bit lf, rt;
        if (t_free[i] || t_owner[i] != w.owner || t_start[i] != w.blk) continue;
        rt = (i + 1 < t_count) && t_free[i+1];
        lf = (i > 0) && t_free[i-1];
        if (lf && rt) begin
          t_size[i-1] += t_size[i] + t_size[i+1];
          drop_entry(i + 1); drop_entry(i);
        end else if (lf) begin
          t_size[i-1] += t_size[i]; drop_entry(i);
        end else if (rt) begin
          t_size[i] += t_size[i+1]; t_free[i] = 1; drop_entry(i + 1);
        end else begin
          t_free[i] = 1;
        end
        a.st = ST_OK;
        break;
      end
    end
    if (a.st != ST_OK) a.start = 0;
    return a;
  endfunction

  // driver
  int tx_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        // handled at posedge bookkeeping below
      end
      if (!in_valid || acc_flag) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 0;
        end else if (pending_words.size() > 0) begin
          word_t w;
          w = pending_words.pop_front();
          in_valid <= 1;
          mode <= w.op; owner_id <= w.owner;
          request_size <= w.req; block_start <= w.blk;
          tx_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : 0;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    acc_flag <= in_valid && in_ready && !acc_flag ? 1 : (in_valid && in_ready);
    if (in_valid && in_ready) begin
      word_t w;
      answer_t a;
      w = '{op: mode_t'(mode), owner: owner_id, req: request_size, blk: block_start};
      a = heap_apply(w);
      expected_answers.push_back(a);
      if (w.op == MODE_ALLOC && a.st == ST_OK) begin
        live_owner.push_back(w.owner); live_start.push_back(a.start);
      end
    end
  end

  // long receiver hold-off, started once by the stimulus
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) hold_rx <= 0;
    end else if (hold_go && !hold_done) begin
      hold_rx <= 1;
      hold_cnt <= 400;
      hold_done <= 1;
    end
  end

  // receiver
  int rx_gap = 0;
  always @(negedge clk) begin
    if (rst || hold_rx) out_ready <= 0;
    else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1; out_ready <= 0;
    end else begin
      out_ready <= 1;
      if (out_valid && out_ready)
        rx_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: status=%0d start=%0d", status, start_out);
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (status !== e.st || start_out !== e.start) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status=%0d start=%0d got status=%0d start=%0d",
                     e.st, e.start, status, start_out);
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_word(input mode_t op, input logic [7:0] own, input logic [16:0] req,
                          input logic [15:0] blk);
    pending_words.push_back('{op: op, owner: own, req: req, blk: blk});
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_heap(input logic [16:0] v);
    @(negedge clk);
    cfg_wr_en <= 1; cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    heap_reset(v);
    live_owner.delete(); live_start.delete();
    @(negedge clk);
  endtask

  // random phase; sizes mostly small against the heap
  task automatic random_phase(input int n, input int max_req);
    for (int j = 0; j < n; j++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
        add_word(MODE_ALLOC, 8'($urandom_range(0, 255)),
                 $urandom_range(0, 19) == 0 ? 17'($urandom_range(0, 131071))
                                            : 17'($urandom_range(1, max_req)),
                 16'($urandom));
      end else if (r < 90 && live_owner.size() > 0) begin
        int p;
        p = $urandom_range(0, live_owner.size() - 1);
        add_word(MODE_FREE, live_owner[p], 17'($urandom), live_start[p]);
        live_owner.delete(p); live_start.delete(p);
      end else begin
        add_word(MODE_FREE, 8'($urandom_range(0, 255)), 17'($urandom), 16'($urandom));
      end
      // keep live list in step with accepted words
      while (pending_words.size() > 4) @(posedge clk);
    end
  endtask

  initial begin
    heap_reset(HEAP_MAX);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed
    add_word(MODE_ALLOC, 8'hFF, 17'd0, 16'h0);
    add_word(MODE_ALLOC, 8'h00, 17'h1FFFF, 16'hFFFF);
    add_word(MODE_ALLOC, 8'hA5, 17'd1, 16'h0);
    add_word(MODE_ALLOC, 8'h5A, 17'd100, 16'h0);
    add_word(MODE_FREE, 8'hA5, 17'h1FFFF, 16'd0);
    add_word(MODE_FREE, 8'h11, 17'd0, 16'hFFFF);
    add_word(MODE_FREE, 8'h5A, 17'd0, 16'd1);
    add_word(MODE_ALLOC, 8'h01, 17'd65536, 16'h0);
    add_word(MODE_FREE, 8'h01, 17'd0, 16'd0);
    wait_idle();
    // fill the table to force the full status, receiver held off meanwhile
    write_heap(17'd200);
    hold_go = 1;
    for (int j = 0; j < 66; j++) add_word(MODE_ALLOC, j[7:0], 17'd1, 16'h0);
    wait (hold_done && !hold_rx);
    add_word(MODE_ALLOC, 8'h77, 17'd136, 16'h0);
    add_word(MODE_FREE, 8'd1, 17'd0, 16'd1);
    add_word(MODE_FREE, 8'd2, 17'd0, 16'd2);
    add_word(MODE_FREE, 8'd0, 17'd0, 16'd0);
    wait_idle();
    write_heap(17'd0);
    add_word(MODE_ALLOC, 8'h3, 17'd1, 16'h0);
    add_word(MODE_ALLOC, 8'h3, 17'd1, 16'h0);
    add_word(MODE_FREE, 8'h3, 17'd1, 16'h0);
    wait_idle();
    write_heap(17'h1FFFF);
    random_phase(180, 4000);
    wait_idle();
    write_heap(17'd300);
    random_phase(220, 20);
    wait_idle();
    write_heap(17'd65536);
    random_phase(170, 2000);
    wait_idle();
    if (mismatches == 0 && expected_answers.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
